@@ rtl/core/clrb_pkg.sv @@
package clrb_pkg;

  // ring geometry, settled by the 12 bit index and 13 bit length fields
  localparam int unsigned RING_DEPTH = 4096;
  localparam int unsigned IDX_W      = $clog2(RING_DEPTH);
  localparam int unsigned LEN_W      = IDX_W + 1;

  localparam logic [7:0] NEWLINE_BYTE = 8'h0A;

  typedef enum logic [2:0] {
    CMD_APPEND     = 3'd0,
    CMD_END_LINE   = 3'd1,
    CMD_BOOT       = 3'd2,
    CMD_READ_PREV  = 3'd3,
    CMD_CLEAR_PREV = 3'd4
  } cmd_e;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [7:0]  data_byte;
    logic [3:0]  reset_reason;
    logic [11:0] read_index;
  } clrb_in_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic [12:0] previous_length;
    logic        abnormal_boot;
    logic [12:0] ring_length;
  } clrb_out_t;

endpackage

@@ rtl/core/clrb_in_if.sv @@
interface clrb_in_if;
  logic               valid;
  logic               ready;
  clrb_pkg::clrb_in_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

@@ rtl/core/clrb_out_if.sv @@
interface clrb_out_if;
  logic                valid;
  logic                ready;
  clrb_pkg::clrb_out_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

@@ rtl/core/crash_log_ring_buffer_top.sv @@
// crash log ring buffer: keeps the most recent 4096 log bytes in a ring memory
// and, on a boot item whose reset reason is abnormal (unknown, panic, any
// watchdog or brownout), copies the valid, non-empty ring oldest-first into a
// second memory, the previous store, which read items then index. every item
// gives exactly one result, carrying the lengths and abnormal flag after the
// update, and read_data for read items (zero otherwise or out of range).
// append, end line, read, clear and plain boot items run at one item per
// cycle while the output takes results; a result passes through stage 1,
// which waits on the registered read port of the previous store, and then
// the output register. a boot item that triggers the copy holds off input
// while a single sequencer streams the ring memory read port into the
// previous store write port, one byte a cycle. no clearing pass after reset.
module crash_log_ring_buffer_top (
  input  logic clk_i,
  input  logic rst_ni,
  clrb_in_if.sink    in_i,
  clrb_out_if.source out_o
);
  import clrb_pkg::*;

  localparam logic [LEN_W-1:0] DEPTH_LEN = LEN_W'(RING_DEPTH);

  // reset reason codes that count as abnormal
  localparam logic [3:0] RSN_UNKNOWN  = 4'd0;
  localparam logic [3:0] RSN_PANIC    = 4'd4;
  localparam logic [3:0] RSN_INTWDT   = 4'd5;
  localparam logic [3:0] RSN_TASKWDT  = 4'd6;
  localparam logic [3:0] RSN_WDT      = 4'd7;
  localparam logic [3:0] RSN_BROWNOUT = 4'd9;

  typedef enum logic {
    ST_RUN,
    ST_COPY
  } state_e;

  function automatic logic reason_abnormal(input logic [3:0] r);
    return (r == RSN_UNKNOWN) || (r == RSN_PANIC) || (r == RSN_INTWDT) ||
           (r == RSN_TASKWDT) || (r == RSN_WDT) || (r == RSN_BROWNOUT);
  endfunction

  // control and ring bookkeeping
  state_e           state_q, state_d;
  logic [IDX_W-1:0] head_q, head_d;
  logic [LEN_W-1:0] used_q, used_d;
  logic             ring_valid_q, ring_valid_d;
  logic             line_open_q, line_open_d;
  logic [LEN_W-1:0] prev_len_q, prev_len_d;
  logic             abnormal_q, abnormal_d;

  // copy sequencer
  logic [LEN_W-1:0] copy_cnt_q, copy_cnt_d;
  logic [LEN_W-1:0] copy_len_q, copy_len_d;
  logic [IDX_W-1:0] copy_rd_addr_q, copy_rd_addr_d;
  logic             wr_valid_q, wr_valid_d;
  logic [IDX_W-1:0] wr_addr_q, wr_addr_d;

  // result pipeline: stage 1 waits for the memory read, then the output register
  logic             s1_valid_q, s1_valid_d;
  logic             s1_rd_q, s1_rd_d;
  clrb_out_t        s1_res_q, s1_res_d;
  logic             out_valid_q, out_valid_d;
  clrb_out_t        out_res_q, out_res_d;

  // memories
  logic [7:0] ring_mem [RING_DEPTH];
  logic [7:0] prev_mem [RING_DEPTH];
  logic [7:0] ring_rdata_q;
  logic [7:0] prev_rdata_q;

  logic             in_fire;
  logic             s1_ready;
  logic             ring_we;
  logic [7:0]       ring_wdata;
  logic             ring_re;
  logic             prev_re;
  logic             start_copy;
  logic [IDX_W-1:0] head_base;
  logic [LEN_W-1:0] used_base;
  logic             do_put;
  logic             boot_abn;

  assign s1_ready    = !out_valid_q || out_o.ready;
  assign in_i.ready  = (state_q == ST_RUN) && (!s1_valid_q || s1_ready);
  assign in_fire     = in_i.valid && in_i.ready;
  assign out_o.valid = out_valid_q;
  assign out_o.payload = out_res_q;

  assign boot_abn = reason_abnormal(in_i.payload.reset_reason);
  assign ring_re  = (state_q == ST_COPY) && (copy_cnt_q != copy_len_q);
  assign prev_re  = in_fire && (in_i.payload.cmd == CMD_READ_PREV);

  // item decode and state update
  always_comb begin
    head_d       = head_q;
    used_d       = used_q;
    ring_valid_d = ring_valid_q;
    line_open_d  = line_open_q;
    prev_len_d   = prev_len_q;
    abnormal_d   = abnormal_q;
    ring_wdata   = in_i.payload.data_byte;
    do_put       = 1'b0;
    start_copy   = 1'b0;
    head_base    = head_q;
    used_base    = used_q;

    if (in_fire) begin
      unique case (in_i.payload.cmd)
        CMD_APPEND: begin
          // first byte into an invalid ring starts it from scratch
          if (!ring_valid_q) begin
            head_base = '0;
            used_base = '0;
          end
          ring_valid_d = 1'b1;
          line_open_d  = 1'b1;
          do_put       = 1'b1;
        end
        CMD_END_LINE: begin
          // newline only closes a line that holds something
          if (line_open_q) begin
            ring_wdata  = NEWLINE_BYTE;
            line_open_d = 1'b0;
            do_put      = 1'b1;
          end
        end
        CMD_BOOT: begin
          abnormal_d = boot_abn;
          if (boot_abn && ring_valid_q && (used_q != '0)) begin
            start_copy = 1'b1;
            prev_len_d = used_q;
          end
          head_d       = '0;
          used_d       = '0;
          ring_valid_d = 1'b1;
          line_open_d  = 1'b0;
        end
        CMD_CLEAR_PREV: prev_len_d = '0;
        default: ;
      endcase

      if (do_put) begin
        head_d = head_base + 1'b1;
        used_d = (used_base == DEPTH_LEN) ? used_base : used_base + 1'b1;
      end
    end
  end

  assign ring_we = do_put;

  // copy sequencer and result pipeline next state
  always_comb begin
    state_d        = state_q;
    copy_cnt_d     = copy_cnt_q;
    copy_len_d     = copy_len_q;
    copy_rd_addr_d = copy_rd_addr_q;
    wr_valid_d     = 1'b0;
    wr_addr_d      = wr_addr_q;

    unique case (state_q)
      ST_RUN: begin
        if (start_copy) begin
          state_d        = ST_COPY;
          copy_cnt_d     = '0;
          copy_len_d     = used_q;
          // oldest byte sits used_q behind the head, modulo the ring size
          copy_rd_addr_d = head_q - used_q[IDX_W-1:0];
        end
      end
      ST_COPY: begin
        if (ring_re) begin
          copy_cnt_d     = copy_cnt_q + 1'b1;
          copy_rd_addr_d = copy_rd_addr_q + 1'b1;
          wr_valid_d     = 1'b1;
          wr_addr_d      = copy_cnt_q[IDX_W-1:0];
        end else if (!wr_valid_q) begin
          state_d = ST_RUN;
        end
      end
      default: state_d = ST_RUN;
    endcase

    s1_valid_d = s1_valid_q;
    s1_rd_d    = s1_rd_q;
    s1_res_d   = s1_res_q;
    if (in_fire) begin
      s1_valid_d = 1'b1;
      s1_rd_d    = prev_re && ({1'b0, in_i.payload.read_index} < prev_len_q);
      s1_res_d.read_data       = '0;
      s1_res_d.previous_length = prev_len_d;
      s1_res_d.abnormal_boot   = abnormal_d;
      s1_res_d.ring_length     = used_d;
    end else if (s1_ready) begin
      s1_valid_d = 1'b0;
    end

    out_valid_d = out_valid_q;
    out_res_d   = out_res_q;
    if (s1_valid_q && s1_ready) begin
      out_valid_d         = 1'b1;
      out_res_d           = s1_res_q;
      out_res_d.read_data = s1_rd_q ? prev_rdata_q : 8'h00;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_RUN;
      head_q         <= '0;
      used_q         <= '0;
      ring_valid_q   <= 1'b0;
      line_open_q    <= 1'b0;
      prev_len_q     <= '0;
      abnormal_q     <= 1'b0;
      copy_cnt_q     <= '0;
      copy_len_q     <= '0;
      copy_rd_addr_q <= '0;
      wr_valid_q     <= 1'b0;
      wr_addr_q      <= '0;
      s1_valid_q     <= 1'b0;
      s1_rd_q        <= 1'b0;
      s1_res_q       <= '0;
      out_valid_q    <= 1'b0;
      out_res_q      <= '0;
    end else begin
      state_q        <= state_d;
      head_q         <= head_d;
      used_q         <= used_d;
      ring_valid_q   <= ring_valid_d;
      line_open_q    <= line_open_d;
      prev_len_q     <= prev_len_d;
      abnormal_q     <= abnormal_d;
      copy_cnt_q     <= copy_cnt_d;
      copy_len_q     <= copy_len_d;
      copy_rd_addr_q <= copy_rd_addr_d;
      wr_valid_q     <= wr_valid_d;
      wr_addr_q      <= wr_addr_d;
      s1_valid_q     <= s1_valid_d;
      s1_rd_q        <= s1_rd_d;
      s1_res_q       <= s1_res_d;
      out_valid_q    <= out_valid_d;
      out_res_q      <= out_res_d;
    end
  end

  // ring memory: written at the head by appends and end lines, read only by the copy
  always_ff @(posedge clk_i) begin
    if (ring_we) begin
      ring_mem[head_base] <= ring_wdata;
    end
    if (ring_re) begin
      ring_rdata_q <= ring_mem[copy_rd_addr_q];
    end
  end

  // previous store: written by the copy, read by read items
  always_ff @(posedge clk_i) begin
    if (wr_valid_q) begin
      prev_mem[wr_addr_q] <= ring_rdata_q;
    end
    if (prev_re) begin
      prev_rdata_q <= prev_mem[in_i.payload.read_index];
    end
  end

`ifndef SYNTHESIS
  a_copy_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_copy |=> (state_q == ST_COPY))
    else $error("abnormal boot with a filled ring did not start the copy");

  a_no_input_in_copy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_COPY) |-> !in_i.ready)
    else $error("input taken while the ring is being copied");

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (used_q <= DEPTH_LEN) && (prev_len_q <= DEPTH_LEN))
    else $error("ring or previous length beyond the ring size");

  a_copy_write_in_copy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_valid_q |-> (state_q == ST_COPY) && !prev_re)
    else $error("previous store written outside the copy");
`endif

endmodule
